// ===== hw/rtl/lrupl_pkg.sv =====
// Shared constants, codes and types of the LRU page replacement list.
package lrupl_pkg;

    // List geometry
    localparam int NUM_FRAMES   = 8;
    localparam int PAGE_ID_BITS = 16;
    localparam int ADDR_W       = $clog2(NUM_FRAMES);
    localparam int CNT_W        = $clog2(NUM_FRAMES + 1);

    // Widths of the stream fields
    localparam int PAGE_IN_W = 16;
    localparam int VICTIM_W  = 16;
    localparam int OCC_W     = 4;
    localparam int STATUS_W  = 3;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_MOVED    = 3'd1,
        STAT_EVICTED  = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_EMPTY    = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_EV_RD,
        ST_EV_DATA,
        ST_DONE
    } t_state;

    // One cycle of accesses to the recency store
    typedef struct packed {
        logic                    rd_en;
        logic [ADDR_W-1:0]       rd_addr;
        logic                    wr_en;
        logic [ADDR_W-1:0]       wr_addr;
        logic [PAGE_ID_BITS-1:0] wr_data;
    } t_mem_req;

endpackage

// ===== hw/rtl/lru_page_replacement_list_core.sv =====
// LRU page replacement list: top level with request sequencer and result register.
//
// Keeps up to NUM_FRAMES resident page identifiers in recency order, slot 0 the
// most recent, in a small single-read-port memory. A touch word (tuser 0) walks
// the list once to look for the page, then walks it again up to the hit slot,
// or up to the end when the page is new, moving each entry one slot down and
// writing the page into slot 0. A touch of a page that is not present when the
// list is full is rejected and leaves the list unchanged. An evict word
// (tuser 1) reads the last slot and returns it as the victim; evicting from an
// empty list returns the empty status. One result word comes out per request.
// The walks through the memory read port move one slot per cycle. A result
// that waits in the output register does not block the next request, which
// is held back only at its final step until the register is free.
module lru_page_replacement_list_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] page_id
    input  logic [0:0]  i_s_tuser,   // [0] req_type
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] victim_page, [19:16] occupancy, [23:20] zero
    output logic [2:0]  o_m_tuser    // [2:0] status
);

    localparam int PW = lrupl_pkg::PAGE_ID_BITS;
    localparam int AW = lrupl_pkg::ADDR_W;
    localparam int CW = lrupl_pkg::CNT_W;

    // Control registers
    lrupl_pkg::t_state  r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_out_valid, n_out_valid;

    // Payload registers
    logic [AW-1:0]                   r_pend_idx, n_pend_idx;
    logic [AW-1:0]                   r_upto, n_upto;
    logic [PW-1:0]                   r_page, n_page;
    logic [PW-1:0]                   r_carry, n_carry;
    lrupl_pkg::t_status              r_st, n_st;
    logic [lrupl_pkg::VICTIM_W-1:0]  r_vic, n_vic;
    lrupl_pkg::t_status              r_out_st, n_out_st;
    logic [lrupl_pkg::VICTIM_W-1:0]  r_out_vic, n_out_vic;
    logic [lrupl_pkg::OCC_W-1:0]     r_out_occ, n_out_occ;

    lrupl_pkg::t_mem_req mem_req;
    logic [PW-1:0]       rd_data;
    logic [31:0]         page_wide;
    logic [31:0]         data_wide;
    logic [31:0]         count_wide;
    logic [CW-1:0]       last_slot;
    logic                hit_now;

    lrupl_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Width adaptation between stream fields and list words
    assign page_wide  = 32'(i_s_tdata);
    assign data_wide  = 32'(rd_data);
    assign count_wide = 32'(r_count);
    assign last_slot  = r_count - CW'(1);
    assign hit_now    = r_pend && (rd_data == r_page);

    assign o_s_tready = (r_state == lrupl_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_occ, r_out_vic};
    assign o_m_tuser  = r_out_st;

    // Sequencer: next state, memory accesses and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_upto      = r_upto;
        n_page      = r_page;
        n_carry     = r_carry;
        n_st        = r_st;
        n_vic       = r_vic;
        n_out_valid = r_out_valid;
        n_out_st    = r_out_st;
        n_out_vic   = r_out_vic;
        n_out_occ   = r_out_occ;
        mem_req     = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lrupl_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_page = page_wide[PW-1:0];
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_vic  = '0;
                    if (i_s_tuser[0]) begin
                        if (r_count == '0) begin
                            n_st    = lrupl_pkg::STAT_EMPTY;
                            n_state = lrupl_pkg::ST_DONE;
                        end else begin
                            n_state = lrupl_pkg::ST_EV_RD;
                        end
                    end else begin
                        n_state = lrupl_pkg::ST_SEARCH;
                    end
                end
            end

            // Look for the page, one slot read per cycle
            lrupl_pkg::ST_SEARCH: begin
                if (hit_now) begin
                    n_st    = lrupl_pkg::STAT_MOVED;
                    n_upto  = r_pend_idx;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_carry = r_page;
                    n_state = lrupl_pkg::ST_SHIFT;
                end else if (!r_pend && (r_idx == r_count)) begin
                    if (r_count == CW'(lrupl_pkg::NUM_FRAMES)) begin
                        n_st    = lrupl_pkg::STAT_FULL;
                        n_state = lrupl_pkg::ST_DONE;
                    end else begin
                        n_st    = lrupl_pkg::STAT_INSERTED;
                        n_upto  = r_count[AW-1:0];
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_carry = r_page;
                        n_state = lrupl_pkg::ST_SHIFT;
                    end
                end else if (r_idx < r_count) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_idx[AW-1:0];
                    n_idx           = r_idx + CW'(1);
                    n_pend          = 1'b1;
                    n_pend_idx      = r_idx[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
            end

            // Move slots down by one: write the carried word, carry the old one
            lrupl_pkg::ST_SHIFT: begin
                if (r_pend) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_pend_idx;
                    mem_req.wr_data = r_carry;
                    n_carry         = rd_data;
                end
                if (r_idx < CW'(r_upto)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_idx[AW-1:0];
                    n_idx           = r_idx + CW'(1);
                    n_pend          = 1'b1;
                    n_pend_idx      = r_idx[AW-1:0];
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    // last carried word lands in the hit slot or the new tail
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_upto;
                    mem_req.wr_data = r_carry;
                    if (r_st == lrupl_pkg::STAT_INSERTED) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = lrupl_pkg::ST_DONE;
                end
            end

            // Evict: read the least recent slot
            lrupl_pkg::ST_EV_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = last_slot[AW-1:0];
                n_state         = lrupl_pkg::ST_EV_DATA;
            end

            lrupl_pkg::ST_EV_DATA: begin
                n_vic   = data_wide[lrupl_pkg::VICTIM_W-1:0];
                n_st    = lrupl_pkg::STAT_EVICTED;
                n_count = last_slot;
                n_state = lrupl_pkg::ST_DONE;
            end

            // Hand the result word to the output register once it is free
            lrupl_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_st;
                    n_out_vic   = r_vic;
                    n_out_occ   = count_wide[lrupl_pkg::OCC_W-1:0];
                    n_state     = lrupl_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lrupl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrupl_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_upto     <= n_upto;
        r_page     <= n_page;
        r_carry    <= n_carry;
        r_st       <= n_st;
        r_vic      <= n_vic;
        r_out_st   <= n_out_st;
        r_out_vic  <= n_out_vic;
        r_out_occ  <= n_out_occ;
    end

`ifndef ASSERT_OFF
    // occupancy never exceeds the number of frames
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(lrupl_pkg::NUM_FRAMES))
        else $error("list occupancy above frame count");

    // the shift walk never reads the slot it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("read and write of one slot in a cycle");

    // reads stay within the occupied part of the list
    a_rd_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.rd_en |-> (CW'(mem_req.rd_addr) < r_count))
        else $error("read beyond the list tail");

    // a result word is loaded only from the final step of a request
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !r_out_valid) |-> (r_state == lrupl_pkg::ST_DONE))
        else $error("result word loaded outside the final step");
`endif

endmodule

// ===== hw/rtl/lrupl_store.sv =====
// Recency store: one write port, one registered read port.
module lrupl_store (
    input  logic                              i_clk,
    input  lrupl_pkg::t_mem_req               i_req,
    output logic [lrupl_pkg::PAGE_ID_BITS-1:0] o_rd_data
);

    logic [lrupl_pkg::PAGE_ID_BITS-1:0] r_mem [lrupl_pkg::NUM_FRAMES];
    logic [lrupl_pkg::PAGE_ID_BITS-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read port, registered, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
